// ===== hdl/ppac_pkg.sv =====
package ppac_pkg;

    localparam int CHANNEL_COUNT = 192;
    localparam int LANE_COUNT    = 3;
    localparam int LANE_CHANNELS = CHANNEL_COUNT / LANE_COUNT;
    localparam int SAMPLE_DEPTH  = 512;

    localparam int CHAN_W     = $clog2(LANE_CHANNELS);
    localparam int SAMP_W     = $clog2(SAMPLE_DEPTH);
    localparam int SMP_ADDR_W = CHAN_W + SAMP_W;
    localparam int SMP_ENTRIES = LANE_CHANNELS * SAMPLE_DEPTH;

    localparam int VALUE_W = 10;
    localparam int THR_W   = 16;
    localparam int SUM_W   = 19;
    localparam int HIT_W   = 16;
    localparam int WORD_W  = 24;
    localparam int RCHAN_W = 8;
    localparam int LANE_W  = 2;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UPDATE,
        ST_REPLY
    } t_state;

    // Contribution of one stored value to its channel sum.
    function automatic logic [VALUE_W-1:0] share_of(input logic [VALUE_W-1:0] v,
                                                   input logic [THR_W-1:0] thr);
        logic [VALUE_W-1:0] res;
        res = '0;
        if ((v != '0) && ({{(THR_W-VALUE_W){1'b0}}, v} >= thr)) begin
            res = v - thr[VALUE_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/ppac_strip_sample_accumulator_top.sv =====
// Strip sample accumulator. Items are accepted when start is high and busy is low. For a data item,
// the three lane memories (channels c, c+64 and c+128) are read in the accept cycle and written
// back with the updated value, sum and hit count in the next. A read item's result is on
// o_strip_sum and o_hit_count with o_valid high for exactly one cycle, the cycle after
// acceptance; the receiver cannot stall it and must take it then.
// A start item, and likewise reset, launches a clearing pass that walks all 32768 rows of the
// lane sample memories one row per cycle, so busy stays high until the last row is cleared.
module ppac_strip_sample_accumulator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_action,
    input  logic [ppac_pkg::THR_W-1:0]      i_event_threshold,
    input  logic [ppac_pkg::WORD_W-1:0]     i_first_word,
    input  logic [ppac_pkg::WORD_W-1:0]     i_second_word,
    input  logic [ppac_pkg::RCHAN_W-1:0]    i_read_channel,
    output logic                            o_valid,
    output logic [ppac_pkg::SUM_W-1:0]      o_strip_sum,
    output logic [ppac_pkg::HIT_W-1:0]      o_hit_count
);
    import ppac_pkg::*;

    t_state                  r_state, n_state;
    logic [SMP_ADDR_W-1:0]   r_clr_addr;
    logic [THR_W-1:0]        r_thr;
    logic [SMP_ADDR_W-1:0]   r_addr;
    logic [LANE_W-1:0]       r_rd_lane;
    logic [VALUE_W-1:0]      r_val [LANE_COUNT];
    logic [SUM_W-1:0]        r_sum_q [LANE_COUNT];
    logic [HIT_W-1:0]        r_cnt_q [LANE_COUNT];

    logic                    w_accept;
    t_action                 w_action;
    logic [CHAN_W-1:0]       w_chan;
    logic [SAMP_W-1:0]       w_samp;
    logic [VALUE_W-1:0]      w_val_in [LANE_COUNT];
    logic [CHAN_W-1:0]       w_stat_raddr;
    logic                    w_we;
    logic                    w_clearing;
    logic [SMP_ADDR_W-1:0]   w_smp_waddr;
    logic [CHAN_W-1:0]       w_stat_waddr;

    assign w_accept = start && !busy;
    assign w_action = t_action'(i_action);
    assign w_chan   = i_second_word[13:8];
    assign w_samp   = i_second_word[22:14];

    assign w_val_in[0] = i_first_word[9:0];
    assign w_val_in[1] = i_first_word[19:10];
    assign w_val_in[2] = {i_second_word[5:0], i_first_word[23:20]};

    assign w_stat_raddr = (w_action == ACT_READ) ? i_read_channel[CHAN_W-1:0] : w_chan;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_action)
                        ACT_START: n_state = ST_CLEAR;
                        ACT_DATA:  n_state = ST_UPDATE;
                        ACT_READ:  n_state = ST_REPLY;
                        ACT_NONE:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_UPDATE: n_state = ST_IDLE;
            ST_REPLY:  n_state = ST_IDLE;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        busy         = (r_state != ST_IDLE);
        o_valid      = (r_state == ST_REPLY);
        w_clearing   = (r_state == ST_CLEAR);
        w_we         = w_clearing || (r_state == ST_UPDATE);
        w_smp_waddr  = w_clearing ? r_clr_addr : r_addr;
        w_stat_waddr = w_clearing ? r_clr_addr[CHAN_W-1:0] : r_addr[SMP_ADDR_W-1 -: CHAN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_thr      <= '0;
        end else begin
            r_state <= n_state;
            if (w_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_accept && (w_action == ACT_START)) begin
                r_thr      <= i_event_threshold;
                r_clr_addr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr    <= {w_chan, w_samp};
            r_rd_lane <= i_read_channel[RCHAN_W-1 -: LANE_W];
            for (int k = 0; k < LANE_COUNT; k++) begin
                r_val[k] <= w_val_in[k];
            end
        end
    end

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        logic [VALUE_W-1:0]       mem_smp  [SMP_ENTRIES];
        logic [SUM_W+HIT_W-1:0]   mem_stat [LANE_CHANNELS];
        logic [VALUE_W-1:0]       r_old_q;
        logic [SUM_W-1:0]         w_sum_new;
        logic [HIT_W-1:0]         w_cnt_new;
        logic [VALUE_W-1:0]       w_smp_wdata;
        logic [SUM_W+HIT_W-1:0]   w_stat_wdata;

        always_comb begin
            // The old value's share comes out before the new one goes in.
            w_sum_new = r_sum_q[g]
                      - {{(SUM_W-VALUE_W){1'b0}}, share_of(r_old_q, r_thr)}
                      + {{(SUM_W-VALUE_W){1'b0}}, share_of(r_val[g], r_thr)};
            w_cnt_new = r_cnt_q[g];
            if ((r_val[g] != '0) && (r_cnt_q[g] != HIT_MAX)) begin
                w_cnt_new = r_cnt_q[g] + 1'b1;
            end
            w_smp_wdata  = w_clearing ? '0 : r_val[g];
            w_stat_wdata = w_clearing ? '0 : {w_sum_new, w_cnt_new};
        end

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                mem_smp[w_smp_waddr]   <= w_smp_wdata;
                mem_stat[w_stat_waddr] <= w_stat_wdata;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                r_old_q                <= mem_smp[{w_chan, w_samp}];
                {r_sum_q[g], r_cnt_q[g]} <= mem_stat[w_stat_raddr];
            end
        end
    end

    always_comb begin
        unique case (r_rd_lane)
            2'd0: begin
                o_strip_sum = r_sum_q[0];
                o_hit_count = r_cnt_q[0];
            end
            2'd1: begin
                o_strip_sum = r_sum_q[1];
                o_hit_count = r_cnt_q[1];
            end
            2'd2: begin
                o_strip_sum = r_sum_q[2];
                o_hit_count = r_cnt_q[2];
            end
            default: begin
                // Channels past the last strip read as empty.
                o_strip_sum = '0;
                o_hit_count = '0;
            end
        endcase
    end

    a_valid_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept && (w_action == ACT_READ)))
        else $error("result strobe without an accepted read item");

    a_data_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_DATA)) |=> (r_state == ST_UPDATE) && busy)
        else $error("data item not written back in the following cycle");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_START)) |=> w_clearing && (r_clr_addr == '0))
        else $error("start item did not begin a clearing pass from row zero");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_clearing && (r_clr_addr == '1)) |=> !busy && !o_valid)
        else $error("clearing pass did not return to idle");

endmodule
